// File: rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, register codes and the round mixing function of the XTEA unit.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int MODE_W     = 2;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E3779B9;

  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_XTEA = 2'd1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic STATUS_DONE        = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  typedef logic [3:0][WORD_W-1:0] xtea_key_t;

  typedef struct packed {
    logic [MODE_W-1:0] cipher_mode;
    xtea_key_t         key;
  } xtea_cfg_t;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] block_word_0;
    logic [WORD_W-1:0] block_word_1;
    logic [WORD_W-1:0] block_word_2;
    logic [WORD_W-1:0] block_word_3;
  } xtea_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word_0;
    logic [WORD_W-1:0] result_word_1;
    logic [WORD_W-1:0] result_word_2;
    logic [WORD_W-1:0] result_word_3;
    logic              status;
  } xtea_out_t;

  // one pipeline slot: control bits plus the four data words
  typedef struct packed {
    logic                   valid;
    logic                   op;
    logic                   run;
    logic                   status;
    logic [3:0][WORD_W-1:0] v;
  } xtea_lane_t;

  function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] x);
    xtea_mix = ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

// File: rtl/xtea_cfg_regs.sv
// ----------------------------------------------------------------------------
// xtea_cfg_regs
// Mode and key registers behind the plain write port. Unknown indexes ignored.
// ----------------------------------------------------------------------------
module xtea_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]      cfg_data,
  output xtea_pkg::xtea_cfg_t              cfg
);
  import xtea_pkg::*;

  xtea_cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CIPHER_MODE: cfg_next.cipher_mode = cfg_data[MODE_W-1:0];
        CFG_KEY_WORD_0:  cfg_next.key[0] = cfg_data;
        CFG_KEY_WORD_1:  cfg_next.key[1] = cfg_data;
        CFG_KEY_WORD_2:  cfg_next.key[2] = cfg_data;
        CFG_KEY_WORD_3:  cfg_next.key[3] = cfg_data;
        default:         cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// File: rtl/xtea_round_stage.sv
// ----------------------------------------------------------------------------
// xtea_round_stage
// One registered Feistel half-round for both 64-bit blocks, either direction.
// ----------------------------------------------------------------------------
module xtea_round_stage #(
  parameter int CYCLE_COUNT = 32,
  parameter int STAGE       = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  xtea_pkg::xtea_key_t  key,
  input  xtea_pkg::xtea_lane_t lane_in,
  output xtea_pkg::xtea_lane_t lane_out
);
  import xtea_pkg::*;

  localparam int ODD      = STAGE % 2;
  localparam int PAIR     = STAGE / 2;
  localparam int ENC_MULT = PAIR + ODD;
  localparam int DEC_MULT = CYCLE_COUNT - PAIR - ODD;

  localparam logic [63:0] ENC_PROD = 64'(ENC_MULT) * 64'(XTEA_DELTA);
  localparam logic [63:0] DEC_PROD = 64'(DEC_MULT) * 64'(XTEA_DELTA);
  localparam logic [WORD_W-1:0] ENC_SUM = ENC_PROD[WORD_W-1:0];
  localparam logic [WORD_W-1:0] DEC_SUM = DEC_PROD[WORD_W-1:0];

  // even stages: encrypt updates v0 keyed by sum[1:0], decrypt updates v1 by sum[12:11]
  localparam logic [1:0] ENC_KEY_IDX = (ODD != 0) ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam logic [1:0] DEC_KEY_IDX = (ODD != 0) ? DEC_SUM[1:0] : DEC_SUM[12:11];
  localparam logic       STAGE_ODD   = (ODD != 0);

  xtea_lane_t        lane_next;
  logic              dst_hi;
  logic [WORD_W-1:0] kc;

  always_comb begin
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] nd;
    lane_next = lane_in;
    dst_hi    = STAGE_ODD ^ lane_in.op;
    kc        = (lane_in.op == OP_DECRYPT) ? (DEC_SUM + key[DEC_KEY_IDX])
                                           : (ENC_SUM + key[ENC_KEY_IDX]);
    for (int b = 0; b < 2; b++) begin
      src = dst_hi ? lane_in.v[2*b]   : lane_in.v[2*b+1];
      dst = dst_hi ? lane_in.v[2*b+1] : lane_in.v[2*b];
      t   = xtea_mix(src) ^ kc;
      nd  = (lane_in.op == OP_DECRYPT) ? (dst - t) : (dst + t);
      if (lane_in.run) begin
        if (dst_hi) begin
          lane_next.v[2*b+1] = nd;
        end else begin
          lane_next.v[2*b] = nd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out.valid <= lane_next.valid;
    end
    lane_out.op     <= lane_next.op;
    lane_out.run    <= lane_next.run;
    lane_out.status <= lane_next.status;
    lane_out.v      <= lane_next.v;
  end

endmodule

// File: rtl/xtea_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// xtea_block_cipher_unit
// XTEA encrypt/decrypt (or pass-through) of two 64-bit blocks per transaction, fully pipelined.
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high; busy stays low, so one
// transaction per clock is sustained. Each transaction runs through
// 2*CYCLE_COUNT registered half-round stages, and its result is on response
// with done high for one cycle, from the last stage register, in issue order.
// The receiver cannot stall. The mode is sampled when a transaction is
// accepted and the key words as it moves through the stages, so write them
// only while no transaction is in flight.
module xtea_block_cipher_unit #(
  parameter int CYCLE_COUNT = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  xtea_pkg::xtea_in_t             request,
  output logic                           done,
  output xtea_pkg::xtea_out_t            response,
  input  logic                           cfg_we,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]    cfg_data
);
  import xtea_pkg::*;

  localparam int STAGE_COUNT = 2 * CYCLE_COUNT;

  xtea_cfg_t  cfg;
  xtea_lane_t lanes [0:STAGE_COUNT];

  xtea_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign busy = 1'b0;

  always_comb begin
    lanes[0].valid  = start && !busy;
    lanes[0].op     = request.op;
    lanes[0].run    = (cfg.cipher_mode == MODE_XTEA);
    lanes[0].status = ((cfg.cipher_mode == MODE_XTEA) || (cfg.cipher_mode == MODE_PASS))
                      ? STATUS_DONE : STATUS_UNSUPPORTED;
    lanes[0].v[0]   = request.block_word_0;
    lanes[0].v[1]   = request.block_word_1;
    lanes[0].v[2]   = request.block_word_2;
    lanes[0].v[3]   = request.block_word_3;
  end

  for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
    xtea_round_stage #(
      .CYCLE_COUNT (CYCLE_COUNT),
      .STAGE       (s)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .key      (cfg.key),
      .lane_in  (lanes[s]),
      .lane_out (lanes[s+1])
    );
  end

  assign done                   = lanes[STAGE_COUNT].valid;
  assign response.result_word_0 = lanes[STAGE_COUNT].v[0];
  assign response.result_word_1 = lanes[STAGE_COUNT].v[1];
  assign response.result_word_2 = lanes[STAGE_COUNT].v[2];
  assign response.result_word_3 = lanes[STAGE_COUNT].v[3];
  assign response.status        = lanes[STAGE_COUNT].status;

endmodule
